FILE: rtl/core/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg: shared constants and types for the thermistor converter
// Segment table, cumulative code sums, field widths and the stage side-band
// record that travels with each beat down the pipeline.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // Field and datapath widths
  localparam int unsigned AdcBits   = 10;
  localparam int unsigned SegCount  = 20;
  localparam int unsigned SegBits   = 5;
  localparam int unsigned DeltaBits = 7;
  localparam int unsigned NumBits   = 14;
  localparam int unsigned QuoBits   = 7;
  localparam int unsigned CelsBits  = 13;
  localparam int unsigned FahrBits  = 14;
  localparam int unsigned OffsBits  = 11;

  // Divider: quotient bits resolved per pipeline stage
  localparam int unsigned DivStepsPerStage = 2;
  localparam int unsigned DivStages = (QuoBits + DivStepsPerStage - 1) / DivStepsPerStage;

  // Fahrenheit path: c*9, magnitude, reciprocal of five
  localparam int unsigned MulBits     = 16;
  localparam int unsigned AbsBits     = 15;
  localparam int unsigned RecipBits   = 16;
  localparam int unsigned ProdBits    = AbsBits + RecipBits;
  localparam int unsigned Recip5Shift = 18;
  localparam logic [RecipBits-1:0] Recip5 = 16'd52429;

  // Clamp values and offsets, tenths of a degree
  localparam logic signed [CelsBits-1:0] HotLimit  = 13'sd1500;
  localparam logic signed [CelsBits-1:0] ColdLimit = -13'sd400;
  localparam logic signed [CelsBits-1:0] SegBias   = 13'sd4;
  localparam logic signed [CelsBits-1:0] SegStep   = 13'sd100;
  localparam logic signed [FahrBits-1:0] FahrBias  = 14'sd320;

  typedef logic [DeltaBits-1:0] delta_t;
  typedef logic [AdcBits-1:0]   code_t;

  // ADC code delta per 10 degree segment, cold end first
  localparam delta_t SegDelta [SegCount] = '{
    7'd25, 7'd39, 7'd61, 7'd83, 7'd102, 7'd113, 7'd112, 7'd101, 7'd85, 7'd67,
    7'd51, 7'd38, 7'd28, 7'd21, 7'd15,  7'd11,  7'd8,   7'd6,   7'd5,  7'd19
  };

  // Sum of the deltas from a segment up to the hot end
  localparam code_t CumSum [SegCount] = '{
    10'd990, 10'd965, 10'd926, 10'd865, 10'd782, 10'd680, 10'd567, 10'd455,
    10'd354, 10'd269, 10'd202, 10'd151, 10'd113, 10'd85,  10'd64,  10'd49,
    10'd38,  10'd30,  10'd24,  10'd19
  };

  typedef enum logic [1:0] {
    KindSeg,
    KindHot,
    KindCold
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [SegBits-1:0] seg;
    logic               want;
  } side_t;

endpackage

FILE: rtl/core/ntc_seg_search.sv
// ----------------------------------------------------------------------------
// ntc_seg_search: segment lookup front end
// Three stages: compare the code against every cumulative sum, pick the
// segment and its remainder, then scale the remainder by 100.
// ----------------------------------------------------------------------------
module ntc_seg_search
  import ntc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  code_t              code_i,
  input  logic               want_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [NumBits-1:0] num_o,
  output delta_t             div_o
);

  logic                s1_valid_q, s2_valid_q, s3_valid_q;
  logic [SegCount-1:0] s1_hit_d, s1_hit_q;
  code_t               s1_code_q;
  logic                s1_want_q;

  side_t               s2_side_d, s2_side_q, s3_side_q;
  delta_t              s2_rem_d, s2_rem_q;
  delta_t              s2_div_d, s2_div_q, s3_div_q;
  code_t               s2_diff;
  logic [NumBits-1:0]  s3_num_d, s3_num_q;

  // Compare against all cumulative sums in parallel
  always_comb begin
    for (int s = 0; s < SegCount; s++) begin
      s1_hit_d[s] = CumSum[s] > code_i;
    end
  end

  // Pick the hottest segment whose sum exceeds the code
  always_comb begin
    s2_side_d.seg  = '0;
    s2_side_d.want = s1_want_q;
    for (int s = 0; s < SegCount - 1; s++) begin
      if (s1_hit_q[s]) begin
        s2_side_d.seg = SegBits'(s);
      end
    end
    if (s1_hit_q[SegCount-1]) begin
      s2_side_d.kind = KindHot;
    end else if (!s1_hit_q[0]) begin
      s2_side_d.kind = KindCold;
    end else begin
      s2_side_d.kind = KindSeg;
    end
    s2_diff  = CumSum[s2_side_d.seg] - s1_code_q;
    s2_rem_d = s2_diff[DeltaBits-1:0];
    s2_div_d = SegDelta[s2_side_d.seg];
  end

  // Scale remainder by 100 with shifts
  always_comb begin
    s3_num_d = ({{(NumBits-DeltaBits){1'b0}}, s2_rem_q} << 6)
             + ({{(NumBits-DeltaBits){1'b0}}, s2_rem_q} << 5)
             + ({{(NumBits-DeltaBits){1'b0}}, s2_rem_q} << 2);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hit_q  <= s1_hit_d;
      s1_code_q <= code_i;
      s1_want_q <= want_i;
      s2_side_q <= s2_side_d;
      s2_rem_q  <= s2_rem_d;
      s2_div_q  <= s2_div_d;
      s3_side_q <= s2_side_q;
      s3_num_q  <= s3_num_d;
      s3_div_q  <= s2_div_q;
    end
  end

  assign valid_o = s3_valid_q;
  assign side_o  = s3_side_q;
  assign num_o   = s3_num_q;
  assign div_o   = s3_div_q;

endmodule

FILE: rtl/core/ntc_frac_div.sv
// ----------------------------------------------------------------------------
// ntc_frac_div: pipelined restoring divider for the segment fraction
// Resolves DivStepsPerStage quotient bits per stage, MSB first.
// ----------------------------------------------------------------------------
module ntc_frac_div
  import ntc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  side_t              side_i,
  input  logic [NumBits-1:0] num_i,
  input  delta_t             div_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [QuoBits-1:0] quo_o
);

  logic               st_valid_q [DivStages];
  side_t              st_side_q  [DivStages];
  logic [NumBits-1:0] st_num_q   [DivStages];
  logic [QuoBits-1:0] st_quo_q   [DivStages];
  delta_t             st_div_q   [DivStages];

  logic               valid_v [DivStages];
  side_t              side_v  [DivStages];
  logic [NumBits-1:0] num_v   [DivStages];
  logic [QuoBits-1:0] quo_v   [DivStages];
  delta_t             div_v   [DivStages];

  logic [NumBits-1:0] num_d [DivStages];
  logic [QuoBits-1:0] quo_d [DivStages];

  // Route each stage's input: port for the first, previous register after
  always_comb begin
    valid_v[0] = valid_i;
    side_v[0]  = side_i;
    num_v[0]   = num_i;
    quo_v[0]   = '0;
    div_v[0]   = div_i;
    for (int k = 1; k < DivStages; k++) begin
      valid_v[k] = st_valid_q[k-1];
      side_v[k]  = st_side_q[k-1];
      num_v[k]   = st_num_q[k-1];
      quo_v[k]   = st_quo_q[k-1];
      div_v[k]   = st_div_q[k-1];
    end
  end

  // Trial subtract for the quotient bits owned by each stage
  always_comb begin
    int                 bpos;
    logic [NumBits-1:0] part;
    logic [NumBits-1:0] trial;
    logic [QuoBits-1:0] q;
    for (int k = 0; k < DivStages; k++) begin
      part = num_v[k];
      q    = quo_v[k];
      for (int j = 0; j < DivStepsPerStage; j++) begin
        bpos  = int'(QuoBits) - 1 - (k * int'(DivStepsPerStage) + j);
        trial = '0;
        if (bpos >= 0) begin
          trial = {{(NumBits-DeltaBits){1'b0}}, div_v[k]} << bpos;
          if (part >= trial) begin
            part    = part - trial;
            q[bpos] = 1'b1;
          end
        end
      end
      num_d[k] = part;
      quo_d[k] = q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivStages; k++) begin
        st_valid_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        st_valid_q[k] <= valid_v[k];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        st_side_q[k] <= side_v[k];
        st_num_q[k]  <= num_d[k];
        st_quo_q[k]  <= quo_d[k];
        st_div_q[k]  <= div_v[k];
      end
    end
  end

  assign valid_o = st_valid_q[DivStages-1];
  assign side_o  = st_side_q[DivStages-1];
  assign quo_o   = st_quo_q[DivStages-1];

endmodule

FILE: rtl/core/ntc_temp_conv.sv
// ----------------------------------------------------------------------------
// ntc_temp_conv: Celsius assembly and Fahrenheit conversion
// Four stages: clamp/offset, times nine, reciprocal multiply, bias and select.
// ----------------------------------------------------------------------------
module ntc_temp_conv
  import ntc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  side_t                      side_i,
  input  logic        [QuoBits-1:0]  quo_i,
  input  logic signed [OffsBits-1:0] offset_i,
  output logic                       valid_o,
  output logic signed [CelsBits-1:0] celsius_o,
  output logic signed [FahrBits-1:0] fahrenheit_o,
  output logic signed [FahrBits-1:0] selected_o
);

  logic                       t1_valid_q, t2_valid_q, t3_valid_q, t4_valid_q;
  logic signed [CelsBits-1:0] t1_c_d, t1_c_q, t2_c_q, t3_c_q, t4_c_q;
  logic                       t1_want_q, t2_want_q, t3_want_q;
  logic signed [CelsBits-1:0] seg_s;
  logic signed [CelsBits-1:0] base;

  logic signed [MulBits-1:0]  t2_m;
  logic        [MulBits-1:0]  t2_mag;
  logic        [AbsBits-1:0]  t2_abs_d, t2_abs_q;
  logic                       t2_neg_q, t3_neg_q;
  logic        [ProdBits-1:0] t3_prod_d, t3_prod_q;

  logic        [ProdBits-Recip5Shift-1:0] t4_quot;
  logic signed [FahrBits-1:0]             t4_quot_s;
  logic signed [FahrBits-1:0]             t4_f_d, t4_f_q, t4_sel_d, t4_sel_q;

  // Build lookup temperature and add calibration
  always_comb begin
    seg_s = $signed({{(CelsBits-SegBits){1'b0}}, side_i.seg}) - SegBias;
    case (side_i.kind)
      KindHot:  base = HotLimit;
      KindCold: base = ColdLimit;
      default:  base = seg_s * SegStep
                     + $signed({{(CelsBits-QuoBits){1'b0}}, quo_i});
    endcase
    t1_c_d = base + $signed({{(CelsBits-OffsBits){offset_i[OffsBits-1]}}, offset_i});
  end

  // Multiply by nine and split into sign and magnitude
  always_comb begin
    t2_m     = (MulBits'(t1_c_q) <<< 3) + MulBits'(t1_c_q);
    t2_mag   = t2_m[MulBits-1] ? unsigned'(-t2_m) : unsigned'(t2_m);
    t2_abs_d = t2_mag[AbsBits-1:0];
  end

  // Divide magnitude by five through the reciprocal
  always_comb begin
    t3_prod_d = ProdBits'(t2_abs_q) * ProdBits'(Recip5);
  end

  // Restore sign, add bias, select output unit
  always_comb begin
    t4_quot   = t3_prod_q[ProdBits-1:Recip5Shift];
    t4_quot_s = $signed({{(FahrBits-(ProdBits-Recip5Shift)){1'b0}}, t4_quot});
    t4_f_d    = t3_neg_q ? (FahrBias - t4_quot_s) : (FahrBias + t4_quot_s);
    t4_sel_d  = t3_want_q ? FahrBits'(t3_c_q) : t4_f_d;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      t3_valid_q <= 1'b0;
      t4_valid_q <= 1'b0;
    end else if (en_i) begin
      t1_valid_q <= valid_i;
      t2_valid_q <= t1_valid_q;
      t3_valid_q <= t2_valid_q;
      t4_valid_q <= t3_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_c_q    <= t1_c_d;
      t1_want_q <= side_i.want;
      t2_c_q    <= t1_c_q;
      t2_want_q <= t1_want_q;
      t2_abs_q  <= t2_abs_d;
      t2_neg_q  <= t2_m[MulBits-1];
      t3_c_q    <= t2_c_q;
      t3_want_q <= t2_want_q;
      t3_neg_q  <= t2_neg_q;
      t3_prod_q <= t3_prod_d;
      t4_c_q    <= t3_c_q;
      t4_f_q    <= t4_f_d;
      t4_sel_q  <= t4_sel_d;
    end
  end

  assign valid_o      = t4_valid_q;
  assign celsius_o    = t4_c_q;
  assign fahrenheit_o = t4_f_q;
  assign selected_o   = t4_sel_q;

endmodule

FILE: rtl/core/ntc_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature: thermistor ADC code to temperature
// Segment lookup, pipelined fraction divide, calibration and unit conversion.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o  | adc_code_i, want_celsius_i
//   out     | output    | out_valid_o/out_stall_i| celsius, fahrenheit, selected
//   cfg     | input     | cfg_we_i               | cfg_wdata_i (calibration)
//
// One beat enters per cycle while no finished result is blocked; each beat
// passes through 3 lookup stages, 4 divider stages (2 quotient bits each, 1 in the
// last) and 4 stages of Celsius/Fahrenheit arithmetic.
// Reset clears all valid bits and the calibration offset to zero.
// A stalled output beat freezes the whole pipeline; in_stall_o follows
// out_stall_i whenever a result is waiting.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature
  import ntc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic        [AdcBits-1:0]  adc_code_i,
  input  logic                       want_celsius_i,
  input  logic                       cfg_we_i,
  input  logic signed [OffsBits-1:0] cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [CelsBits-1:0] celsius_tenths_o,
  output logic signed [FahrBits-1:0] fahrenheit_tenths_o,
  output logic signed [FahrBits-1:0] selected_temperature_o
);

  logic signed [OffsBits-1:0] cal_offset_q;
  logic                       en;

  logic                       srch_valid;
  side_t                      srch_side;
  logic        [NumBits-1:0]  srch_num;
  delta_t                     srch_div;

  logic                       div_valid;
  side_t                      div_side;
  logic        [QuoBits-1:0]  div_quo;

  // Hold every stage while a finished beat waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Calibration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_offset_q <= '0;
    end else if (cfg_we_i) begin
      cal_offset_q <= cfg_wdata_i;
    end
  end

  ntc_seg_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .code_i  (adc_code_i[AdcBits-1:0]),
    .want_i  (want_celsius_i),
    .valid_o (srch_valid),
    .side_o  (srch_side),
    .num_o   (srch_num),
    .div_o   (srch_div)
  );

  ntc_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (srch_valid),
    .side_i  (srch_side),
    .num_i   (srch_num),
    .div_i   (srch_div),
    .valid_o (div_valid),
    .side_o  (div_side),
    .quo_o   (div_quo)
  );

  ntc_temp_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (div_valid),
    .side_i       (div_side),
    .quo_i        (div_quo),
    .offset_i     (cal_offset_q),
    .valid_o      (out_valid_o),
    .celsius_o    (celsius_tenths_o),
    .fahrenheit_o (fahrenheit_tenths_o),
    .selected_o   (selected_temperature_o)
  );

endmodule

FILE: rtl/core/ntc_chk.sv
// ----------------------------------------------------------------------------
// ntc_chk: port-level checks for the thermistor converter
// Watches stall coupling, output stability and result consistency.
// ----------------------------------------------------------------------------
module ntc_chk
  import ntc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic signed [CelsBits-1:0] celsius_tenths_o,
  input  logic signed [FahrBits-1:0] fahrenheit_tenths_o,
  input  logic signed [FahrBits-1:0] selected_temperature_o
);

  // Input side stalls exactly when a result is blocked
  a_stall_couple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not track blocked output");

  // Blocked result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(celsius_tenths_o)
      && $stable(selected_temperature_o))
    else $error("blocked output beat changed");

  // Selected value is one of the two units
  a_sel_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (selected_temperature_o == celsius_tenths_o)
      || (selected_temperature_o == fahrenheit_tenths_o))
    else $error("selected temperature matches neither unit");

  // Results stay inside the reachable range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> celsius_tenths_o >= -13'sd1424 && celsius_tenths_o <= 13'sd2523
      && fahrenheit_tenths_o >= -14'sd2243 && fahrenheit_tenths_o <= 14'sd4861)
    else $error("temperature out of range");

endmodule

bind ntc_adc_to_temperature ntc_chk u_ntc_chk (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_stall_o             (in_stall_o),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .celsius_tenths_o       (celsius_tenths_o),
  .fahrenheit_tenths_o    (fahrenheit_tenths_o),
  .selected_temperature_o (selected_temperature_o)
);
